/* design/ghp_pkg.sv */
// Shared constants, codes and request/result types of the generational handle pool.
package ghp_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int GEN_BITS   = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  handle_index;
    logic [15:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_index;
    logic [15:0] result_generation;
  } rsp_t;

  typedef struct packed {
    logic                busy;
    logic [GEN_BITS-1:0] gen;
  } slot_entry_t;

endpackage

/* design/ghp_slot_mem.sv */
// Slot table memory: busy mark and generation of every slot, registered read.
module ghp_slot_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ghp_pkg::IDX_W-1:0] rd_addr,
  output ghp_pkg::slot_entry_t      rd_data,
  input  logic                      wr_en,
  input  logic [ghp_pkg::IDX_W-1:0] wr_addr,
  input  ghp_pkg::slot_entry_t      wr_data
);

  ghp_pkg::slot_entry_t mem [ghp_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/ghp_stack_mem.sv */
// Freed-index stack memory, registered read.
module ghp_stack_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ghp_pkg::IDX_W-1:0] rd_addr,
  output logic [ghp_pkg::IDX_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [ghp_pkg::IDX_W-1:0] wr_addr,
  input  logic [ghp_pkg::IDX_W-1:0] wr_data
);

  logic [ghp_pkg::IDX_W-1:0] mem [ghp_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/generational_handle_pool_core.sv */
// Top level of the generational handle pool: request sequencer around the two memories.
//
// A request is taken on a rising edge where start is high and busy is low. It carries
// an action (allocate, free, look up) and a handle made of a slot index and a generation.
// Exactly one result comes back per request: out_valid is high for one cycle while
// out_rsp holds the status, the slot index and, for an allocate, the slot's generation.
// The receiver cannot stall, so a result is never held back.
// A free, a lookup or an allocate of a never-used slot passes through the issue and check
// states, an allocate that pops the freed stack through issue, pop and check, and a request
// rejected on its action or index alone or when the pool is full is answered from issue.
// Busy stays high for the whole request, so one request is in flight at a time and a new
// request is not taken before its predecessor's result; the slot memory's read-modify-write
// follows the stack read on a pop. A new request may be taken in the cycle its predecessor's
// result is shown.
// Reset empties the freed stack and sets the fresh-slot counter to one. Slots at or above
// that counter have never been written and count as free with generation zero, so the
// memories need no clearing pass and the block accepts requests right after reset.
module generational_handle_pool_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ghp_pkg::req_t   in_req,
  output logic            out_valid,
  output ghp_pkg::rsp_t   out_rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_POP,
    S_CHECK
  } state_t;

  localparam int unsigned CmpW = (ghp_pkg::CNT_W > 8) ? ghp_pkg::CNT_W : 8;

  state_t                      state_r, state_nxt;
  ghp_pkg::req_t               req_r, req_nxt;
  logic [ghp_pkg::IDX_W-1:0]   slot_r, slot_nxt;
  logic                        fresh_r, fresh_nxt;
  logic [ghp_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ghp_pkg::CNT_W-1:0]   next_fresh_r, next_fresh_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ghp_pkg::rsp_t               out_rsp_r, out_rsp_nxt;

  logic                        slot_rd_en;
  logic [ghp_pkg::IDX_W-1:0]   slot_rd_addr;
  ghp_pkg::slot_entry_t        slot_q;
  ghp_pkg::slot_entry_t        slot_cur;
  logic                        slot_wr_en;
  ghp_pkg::slot_entry_t        slot_wr_data;

  logic                        stk_rd_en;
  logic [ghp_pkg::IDX_W-1:0]   stk_q;
  logic                        stk_wr_en;

  logic                        idx_in_range;
  logic                        gen_match;
  logic [ghp_pkg::IDX_W-1:0]   req_slot;

  ghp_slot_mem u_slot_mem (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_q),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_r),
    .wr_data (slot_wr_data)
  );

  ghp_stack_mem u_stack_mem (
    .clk     (clk),
    .rd_en   (stk_rd_en),
    .rd_addr (ghp_pkg::IDX_W'(count_r - ghp_pkg::CNT_W'(1))),
    .rd_data (stk_q),
    .wr_en   (stk_wr_en),
    .wr_addr (ghp_pkg::IDX_W'(count_r)),
    .wr_data (slot_r)
  );

  assign req_slot     = ghp_pkg::IDX_W'(req_r.handle_index);
  assign idx_in_range = (req_r.handle_index != 8'd0) &&
                        (CmpW'(req_r.handle_index) < CmpW'(next_fresh_r));
  // A never-used slot was not read from memory; it holds generation zero.
  assign slot_cur     = fresh_r ? '0 : slot_q;
  assign gen_match    = slot_cur.busy &&
                        (slot_cur.gen == ghp_pkg::GEN_BITS'(req_r.handle_generation));

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    slot_nxt       = slot_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    next_fresh_nxt = next_fresh_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    slot_rd_en     = 1'b0;
    slot_rd_addr   = req_slot;
    slot_wr_en     = 1'b0;
    slot_wr_data   = '0;
    stk_rd_en      = 1'b0;
    stk_wr_en      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        fresh_nxt = 1'b0;
        case (req_r.action)
          ghp_pkg::ACT_ALLOC: begin
            if (count_r != '0) begin
              stk_rd_en = 1'b1;
              count_nxt = count_r - ghp_pkg::CNT_W'(1);
              state_nxt = S_POP;
            end else if (next_fresh_r < ghp_pkg::CNT_W'(ghp_pkg::SLOT_COUNT)) begin
              slot_nxt       = ghp_pkg::IDX_W'(next_fresh_r);
              fresh_nxt      = 1'b1;
              next_fresh_nxt = next_fresh_r + ghp_pkg::CNT_W'(1);
              state_nxt      = S_CHECK;
            end else begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ghp_pkg::ST_FULL, default: '0};
              state_nxt     = S_IDLE;
            end
          end
          ghp_pkg::ACT_FREE, ghp_pkg::ACT_LOOKUP: begin
            if (idx_in_range) begin
              slot_rd_en = 1'b1;
              slot_nxt   = req_slot;
              state_nxt  = S_CHECK;
            end else begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ghp_pkg::ST_STALE, default: '0};
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{status: ghp_pkg::ST_STALE, default: '0};
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        // The popped index arrives now and addresses the slot read.
        slot_rd_en   = 1'b1;
        slot_rd_addr = stk_q;
        slot_nxt     = stk_q;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (req_r.action)
          ghp_pkg::ACT_ALLOC: begin
            slot_wr_en   = 1'b1;
            slot_wr_data = '{busy: 1'b1, gen: slot_cur.gen};
            out_rsp_nxt  = '{status:            ghp_pkg::ST_OK,
                             result_index:      8'(slot_r),
                             result_generation: 16'(slot_cur.gen)};
          end
          ghp_pkg::ACT_FREE: begin
            if (gen_match) begin
              slot_wr_en   = 1'b1;
              slot_wr_data = '{busy: 1'b0, gen: slot_cur.gen + ghp_pkg::GEN_BITS'(1)};
              stk_wr_en    = 1'b1;
              count_nxt    = count_r + ghp_pkg::CNT_W'(1);
              out_rsp_nxt  = '{status: ghp_pkg::ST_OK, result_index: 8'(slot_r),
                               result_generation: 16'd0};
            end else begin
              out_rsp_nxt  = '{status: ghp_pkg::ST_STALE, default: '0};
            end
          end
          default: begin
            if (gen_match) begin
              out_rsp_nxt = '{status: ghp_pkg::ST_OK, result_index: 8'(slot_r),
                              result_generation: 16'd0};
            end else begin
              out_rsp_nxt = '{status: ghp_pkg::ST_STALE, default: '0};
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      next_fresh_r <= ghp_pkg::CNT_W'(1);
      out_valid_r  <= 1'b0;
      fresh_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      next_fresh_r <= next_fresh_nxt;
      out_valid_r  <= out_valid_nxt;
      fresh_r      <= fresh_nxt;
    end
    req_r     <= req_nxt;
    slot_r    <= slot_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
